>>> src/key_value_text_parser_top_assert.svh
// Assertion macros for the key=value text parser.
// Used by key_value_text_parser_top; no other dependencies.
`ifndef KEY_VALUE_TEXT_PARSER_TOP_ASSERT_SVH
`define KEY_VALUE_TEXT_PARSER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checks a property on every rising clock edge outside reset.
`define KVTP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kvtp assertion failed");
// Checks that an antecedent in one cycle implies a consequent in the next.
`define KVTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kvtp assertion failed");
`else
`define KVTP_ASSERT(label, prop)
`define KVTP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/kvtp_pkg.sv
// Shared types and constants for the key=value text parser.
// Used by kvtp_step and key_value_text_parser_top; no dependencies.
package kvtp_pkg;

    // Parse phases, one-hot.
    typedef enum logic [4:0] {
        PH_SKIP  = 5'b00001,
        PH_KEY   = 5'b00010,
        PH_GAP   = 5'b00100,
        PH_VSKIP = 5'b01000,
        PH_VALUE = 5'b10000
    } phase_t;

    // Token kinds.
    localparam logic [1:0] TK_NONE  = 2'd0;
    localparam logic [1:0] TK_KEY   = 2'd1;
    localparam logic [1:0] TK_VALUE = 2'd2;

    // Pair status codes.
    localparam logic [1:0] PS_VALID  = 2'd0;
    localparam logic [1:0] PS_ODD    = 2'd1;
    localparam logic [1:0] PS_NONHEX = 2'd2;

    // Fatal error codes.
    localparam logic [2:0] FE_NONE    = 3'd0;
    localparam logic [2:0] FE_BADCHAR = 3'd1;
    localparam logic [2:0] FE_TRUNC   = 3'd2;
    localparam logic [2:0] FE_BADPAIR = 3'd3;
    localparam logic [2:0] FE_EMPTY   = 3'd4;
    localparam logic [2:0] FE_NOVALUE = 3'd5;

    // Characters of interest.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Parser state carried from byte to byte.
    typedef struct packed {
        phase_t phase;
        logic   value_odd;
        logic   value_nonhex;
        logic   value_cut;
        logic   stopped;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase: PH_SKIP, value_odd: 1'b0, value_nonhex: 1'b0,
        value_cut: 1'b0, stopped: 1'b0
    };

    // One result item.
    typedef struct packed {
        logic [1:0] token_kind;
        logic [7:0] token_char;
        logic       key_complete;
        logic       pair_complete;
        logic [1:0] pair_status;
        logic [2:0] fatal_error;
        logic       halted;
    } result_t;

endpackage

>>> src/kvtp_step.sv
// Combinational step of the key=value text parser: one byte in, next state
// and one result out. Depends on kvtp_pkg.
module kvtp_step
(
    input  kvtp_pkg::state_t  cur_state,
    input  logic [7:0]        text_byte,
    input  logic              final_byte,
    output kvtp_pkg::state_t  next_state,
    output kvtp_pkg::result_t result
);

    logic blank;
    logic line_end;
    logic delim;
    logic upper;
    logic key_char;
    logic hex_char;
    logic first;
    logic value_byte;
    logic value_end;

    // Character classes.
    assign blank    = (text_byte == kvtp_pkg::CH_SPACE) || (text_byte == kvtp_pkg::CH_TAB);
    assign line_end = (text_byte == kvtp_pkg::CH_LF) || (text_byte == kvtp_pkg::CH_CR);
    assign delim    = (text_byte == kvtp_pkg::CH_EQUAL) || (text_byte == kvtp_pkg::CH_COMMA);
    assign upper    = (text_byte >= 8'h41) && (text_byte <= 8'h5A);
    assign key_char = (text_byte == kvtp_pkg::CH_UNDER)
                   || ((text_byte >= 8'h30) && (text_byte <= 8'h39))
                   || ((text_byte >= 8'h61) && (text_byte <= 8'h7A));
    assign hex_char = ((text_byte >= 8'h30) && (text_byte <= 8'h39))
                   || ((text_byte >= 8'h61) && (text_byte <= 8'h66))
                   || ((text_byte >= 8'h41) && (text_byte <= 8'h46));

    // Phase transitions, token generation and value bookkeeping.
    always_comb
    begin
        next_state = cur_state;
        result     = '0;
        first      = 1'b0;
        value_byte = 1'b0;
        value_end  = 1'b0;

        if (!cur_state.stopped)
        begin
            unique case (cur_state.phase)
                kvtp_pkg::PH_GAP:
                begin
                    if (blank)
                    begin
                        if (final_byte)
                            result.fatal_error = kvtp_pkg::FE_BADPAIR;
                    end
                    else if (delim)
                    begin
                        result.key_complete = 1'b1;
                        next_state.phase    = kvtp_pkg::PH_VSKIP;
                        if (final_byte)
                            result.fatal_error = kvtp_pkg::FE_NOVALUE;
                    end
                    else
                    begin
                        result.fatal_error = kvtp_pkg::FE_BADPAIR;
                    end
                end
                kvtp_pkg::PH_VSKIP:
                begin
                    if (blank)
                    begin
                        if (final_byte)
                            result.fatal_error = kvtp_pkg::FE_NOVALUE;
                    end
                    else
                    begin
                        value_byte = 1'b1;
                    end
                end
                kvtp_pkg::PH_VALUE:
                begin
                    value_byte = 1'b1;
                end
                default:
                begin
                    // Key phase, and skipping before a key for any other code.
                    first = (cur_state.phase != kvtp_pkg::PH_KEY);
                    if (!(first && (line_end || blank || (text_byte == kvtp_pkg::CH_NUL))))
                    begin
                        if (blank)
                        begin
                            next_state.phase = kvtp_pkg::PH_GAP;
                            if (final_byte)
                                result.fatal_error = kvtp_pkg::FE_BADPAIR;
                        end
                        else if (delim)
                        begin
                            result.key_complete = 1'b1;
                            if (first)
                                result.fatal_error = kvtp_pkg::FE_EMPTY;
                            else
                            begin
                                next_state.phase = kvtp_pkg::PH_VSKIP;
                                if (final_byte)
                                    result.fatal_error = kvtp_pkg::FE_NOVALUE;
                            end
                        end
                        else if (upper || key_char)
                        begin
                            result.token_kind = kvtp_pkg::TK_KEY;
                            result.token_char = upper ? (text_byte | kvtp_pkg::CASE_BIT)
                                                      : text_byte;
                            next_state.phase  = kvtp_pkg::PH_KEY;
                            if (final_byte)
                                result.fatal_error = kvtp_pkg::FE_TRUNC;
                        end
                        else
                        begin
                            result.fatal_error = kvtp_pkg::FE_BADCHAR;
                        end
                    end
                end
            endcase

            // Value characters: count, classify and detect the end.
            if (value_byte)
            begin
                if (line_end || blank)
                begin
                    value_end = 1'b1;
                end
                else
                begin
                    next_state.phase = kvtp_pkg::PH_VALUE;
                    if (!cur_state.value_cut)
                    begin
                        if (text_byte == kvtp_pkg::CH_NUL)
                            next_state.value_cut = 1'b1;
                        else
                        begin
                            result.token_kind      = kvtp_pkg::TK_VALUE;
                            result.token_char      = text_byte;
                            next_state.value_odd   = ~cur_state.value_odd;
                            next_state.value_nonhex = cur_state.value_nonhex | ~hex_char;
                        end
                    end
                    value_end = final_byte;
                end
                if (value_end)
                begin
                    result.pair_complete = 1'b1;
                    if (next_state.value_odd)
                        result.pair_status = kvtp_pkg::PS_ODD;
                    else if (next_state.value_nonhex)
                        result.pair_status = kvtp_pkg::PS_NONHEX;
                    else
                        result.pair_status = kvtp_pkg::PS_VALID;
                    next_state.value_odd    = 1'b0;
                    next_state.value_nonhex = 1'b0;
                    next_state.value_cut    = 1'b0;
                    next_state.phase        = kvtp_pkg::PH_SKIP;
                end
            end

            if (result.fatal_error != kvtp_pkg::FE_NONE)
                next_state.stopped = 1'b1;
        end

        result.halted = next_state.stopped;

        // The last byte of a file returns the parser to its start.
        if (final_byte)
            next_state = kvtp_pkg::STATE_RESET;
    end

endmodule

>>> src/key_value_text_parser_top.sv
// Top level of the key=value text parser: input register, parse step, result
// register. Depends on kvtp_pkg, kvtp_step and key_value_text_parser_top_assert.svh.
//
//  Channel  Direction  Handshake           Payload
//  in       to block   in_valid/in_stall   text_byte, final_byte
//  out      from block out_valid/out_stall token_kind .. halted
//
// One byte is accepted per cycle while in_stall is low; its result is offered once the
// byte moves from the input register into the result register.
// The parser state advances as a byte moves from the input register into the
// result register. Reset clears the parser state and both valid flags.
// A stall on the output holds the result register, and the input register
// then stalls the input only once it is itself occupied.
`include "key_value_text_parser_top_assert.svh"

module key_value_text_parser_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] token_kind,
    output logic [7:0] token_char,
    output logic       key_complete,
    output logic       pair_complete,
    output logic [1:0] pair_status,
    output logic [2:0] fatal_error,
    output logic       halted
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic              s1_final_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    kvtp_pkg::state_t  state_reg;
    kvtp_pkg::state_t  state_step;
    kvtp_pkg::result_t res_reg;
    kvtp_pkg::result_t res_step;
    logic              out_load;
    logic              in_take;
    logic              advance;

    // Handshake control.
    assign out_load       = !out_valid_reg || !out_stall;
    assign in_stall       = s1_valid_reg && !out_load;
    assign in_take        = in_valid && !in_stall;
    assign advance        = s1_valid_reg && out_load;
    assign s1_valid_next  = in_take ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? s1_valid_reg : 1'b1;

    // Parse step for the byte in the input register.
    kvtp_step u_step
    (
        .cur_state  (state_reg),
        .text_byte  (s1_byte_reg),
        .final_byte (s1_final_reg),
        .next_state (state_step),
        .result     (res_step)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= kvtp_pkg::STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_step;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= text_byte;
            s1_final_reg <= final_byte;
        end
        if (advance)
            res_reg <= res_step;
    end

    // Outputs.
    assign out_valid     = out_valid_reg;
    assign token_kind    = res_reg.token_kind;
    assign token_char    = res_reg.token_char;
    assign key_complete  = res_reg.key_complete;
    assign pair_complete = res_reg.pair_complete;
    assign pair_status   = res_reg.pair_status;
    assign fatal_error   = res_reg.fatal_error;
    assign halted        = res_reg.halted;

    // A fatal error always comes with the halted flag.
    `KVTP_ASSERT(a_fatal_halts, !out_valid_reg || res_reg.fatal_error == kvtp_pkg::FE_NONE || res_reg.halted)
    // A status is reported only together with the end of a pair.
    `KVTP_ASSERT(a_status_at_end, !out_valid_reg || res_reg.pair_complete || res_reg.pair_status == kvtp_pkg::PS_VALID)
    // A key delimiter and a pair end never share a result.
    `KVTP_ASSERT(a_kc_pc_excl, !out_valid_reg || !(res_reg.key_complete && res_reg.pair_complete))
    // A byte that moves on always leaves a valid result behind it.
    `KVTP_ASSERT_NEXT(a_advance_valid, advance, out_valid_reg)

endmodule
